### hdl/srg_pkg.sv
package srg_pkg;

  // Result kinds, in the order they leave the block.
  localparam logic [1:0] KIND_DIRTY0 = 2'd0;
  localparam logic [1:0] KIND_DIRTY1 = 2'd1;
  localparam logic [1:0] KIND_SRC    = 2'd2;
  localparam logic [1:0] KIND_DST    = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  // One scroll request: the rectangle and the offset.
  typedef struct packed {
    rect_t              r;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } item_t;

  // Everything one request produces, indexed by kind.
  typedef struct packed {
    rect_t [3:0] r;
    logic        four;
  } geom_t;

  // An empty rectangle always reads as all zero.
  function automatic rect_t mk_rect(logic [15:0] x, logic [15:0] y,
                                    logic [14:0] w, logic [14:0] h);
    rect_t res;
    if (w == 15'd0 || h == 15'd0) begin
      res = '0;
    end else begin
      res.x = x;
      res.y = y;
      res.w = w;
      res.h = h;
    end
    return res;
  endfunction

endpackage

### hdl/srg_geom.sv
module srg_geom (
  input  srg_pkg::item_t item,
  output srg_pkg::geom_t geom
);

  logic [16:0] dxe, dye, ax, ay;
  logic        dx_pos, dy_pos, dx_nz, dy_nz, full;
  logic [15:0] rx, ry, rw16, rh16, ax16, ay16;
  logic [15:0] hy, vx, vy, bx, by;
  logic [14:0] vw, vh, bw, bh;
  srg_pkg::rect_t hrect, vrect;

  always_comb begin
    dxe    = {item.dx[15], item.dx};
    dye    = {item.dy[15], item.dy};
    ax     = item.dx[15] ? (17'd0 - dxe) : dxe;
    ay     = item.dy[15] ? (17'd0 - dye) : dye;
    dx_nz  = (item.dx != 16'sd0);
    dy_nz  = (item.dy != 16'sd0);
    dx_pos = dx_nz && !item.dx[15];
    dy_pos = dy_nz && !item.dy[15];
    full   = (ax >= {2'b00, item.r.w}) || (ay >= {2'b00, item.r.h});

    rx   = item.r.x;
    ry   = item.r.y;
    rw16 = {1'b0, item.r.w};
    rh16 = {1'b0, item.r.h};
    ax16 = ax[15:0];
    ay16 = ay[15:0];

    // Strips and overlap; only meaningful on a partial scroll, where the
    // magnitudes are below the rectangle's size.
    hy = dy_pos ? ry : (ry + rh16 - ay16);
    vx = dx_pos ? rx : (rx + rw16 - ax16);
    vy = dy_pos ? (ry + ay16) : ry;
    vw = ax[14:0];
    vh = item.r.h - ay[14:0];
    bw = item.r.w - ax[14:0];
    bh = item.r.h - ay[14:0];
    bx = rx + (dx_pos ? item.dx : 16'sd0);
    by = ry + (dy_pos ? item.dy : 16'sd0);

    hrect = srg_pkg::mk_rect(rx, hy, item.r.w, ay[14:0]);
    vrect = srg_pkg::mk_rect(vx, vy, vw, vh);

    geom = '0;
    if (!dx_nz && !dy_nz) begin
      geom.four = 1'b0;
    end else if (full) begin
      geom.r[srg_pkg::KIND_DIRTY0] = srg_pkg::mk_rect(rx, ry, item.r.w, item.r.h);
      geom.four = 1'b0;
    end else begin
      if (dy_nz) begin
        geom.r[srg_pkg::KIND_DIRTY0] = hrect;
        geom.r[srg_pkg::KIND_DIRTY1] = vrect;
      end else begin
        geom.r[srg_pkg::KIND_DIRTY0] = vrect;
      end
      geom.r[srg_pkg::KIND_SRC] = srg_pkg::mk_rect(bx - item.dx, by - item.dy, bw, bh);
      geom.r[srg_pkg::KIND_DST] = srg_pkg::mk_rect(bx, by, bw, bh);
      geom.four = 1'b1;
    end
  end

endmodule

### hdl/srg_emit.sv
module srg_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  output logic               load_ready,
  input  srg_pkg::geom_t     load_geom,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output srg_pkg::rect_t     rect,
  output logic               last
);

  srg_pkg::geom_t held;
  logic           busy;
  logic [1:0]     idx;
  logic           done;

  always_comb begin
    out_valid  = busy;
    kind       = idx;
    rect       = held.r[idx];
    last       = held.four ? (idx == srg_pkg::KIND_DST) : (idx == srg_pkg::KIND_DIRTY1);
    done       = busy && out_ready && last;
    load_ready = !busy || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= srg_pkg::KIND_DIRTY0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      idx  <= srg_pkg::KIND_DIRTY0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= srg_pkg::KIND_DIRTY0;
    end else if (busy && out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      held <= load_geom;
    end
  end

endmodule

### hdl/scroll_rect_geometry.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   rect_x rect_y rect_w rect_h shift_x shift_y
// output    out_valid / out_ready kind out_x out_y out_w out_h last
//
// A request is held in the input register, its four rectangles are computed
// combinationally and loaded into the result buffer, which then sends one
// rectangle per cycle while out_ready is high: two for a zero offset or a full
// redraw, four for a partial scroll. Sustained rate is therefore set by the
// single result port, and a held request loads as the last result leaves.
// A request passes the input register, then the result buffer. Reset (rst,
// synchronous) empties both. A stalled output holds its result while the
// input register can still take one more request.
module scroll_rect_geometry (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic [14:0]        rect_w,
  input  logic [14:0]        rect_h,
  input  logic signed [15:0] shift_x,
  input  logic signed [15:0] shift_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [14:0]        out_w,
  output logic [14:0]        out_h,
  output logic               last
);

  // Input register: one request waiting for the result buffer.
  srg_pkg::item_t item;
  logic           item_valid;
  srg_pkg::geom_t geom;
  logic           load_ready;
  srg_pkg::rect_t rect;

  // The register frees up in the same cycle its contents move into the
  // result buffer, so back-to-back transfers are possible.
  assign in_ready = !item_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (load_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.r.x <= rect_x;
      item.r.y <= rect_y;
      item.r.w <= rect_w;
      item.r.h <= rect_h;
      item.dx  <= shift_x;
      item.dy  <= shift_y;
    end
  end

  // All geometry for the held request, in one pass of adds and compares.
  srg_geom u_geom (
    .item (item),
    .geom (geom)
  );

  // Result buffer and sequencer over the rectangles of one request.
  srg_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (item_valid),
    .load_ready (load_ready),
    .load_geom  (geom),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .rect       (rect),
    .last       (last)
  );

  assign out_x = rect.x;
  assign out_y = rect.y;
  assign out_w = rect.w;
  assign out_h = rect.h;

endmodule

### hdl/srg_checker.sv
module srg_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic [14:0]        out_w,
  input logic [14:0]        out_h,
  input logic               last
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_x)
      && $stable(out_y) && $stable(out_w) && $stable(out_h) && $stable(last))
    else $error("stalled result changed");

  // Within one request the kinds follow each other without a gap.
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && kind == $past(kind) + 2'd1)
    else $error("result kinds out of sequence");

  // The blit destination always closes a request, the source never does.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == srg_pkg::KIND_DST) == last || kind == srg_pkg::KIND_DIRTY1)
      && !(kind == srg_pkg::KIND_DIRTY0 && last) && !(kind == srg_pkg::KIND_SRC && last))
    else $error("last flag on wrong kind");

  // Empty rectangles read all zero.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_w == 15'd0 || out_h == 15'd0) |->
      out_x == 16'sd0 && out_y == 16'sd0 && out_w == 15'd0 && out_h == 15'd0)
    else $error("empty rectangle not zeroed");

endmodule

bind scroll_rect_geometry srg_checker u_srg_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_w     (out_w),
  .out_h     (out_h),
  .last      (last)
);

### test/scroll_rect_geometry_test.sv
`timescale 1ns / 1ps

module scroll_rect_geometry_test;

  // Limit on consecutive cycles with no transfer on either channel. The
  // longest stall in a correct run is the receiver's long hold-off below.
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;
  localparam int RANDOM_REQUESTS = 360;

  // One expected rectangle as it leaves the result channel.
  typedef struct packed {
    logic [1:0]      kind;
    srg_pkg::rect_t  r;
    logic            last;
  } scroll_res_t;

  // One row of the directed table. When lit is set, the request is a zero
  // offset or a full redraw: the first dirty rectangle is given literally
  // and the second one is empty. Other rows go through the predictor.
  typedef struct packed {
    srg_pkg::item_t req;
    logic           lit;
    srg_pkg::rect_t first;
  } dir_row_t;

  localparam int NUM_ROWS = 24;

  dir_row_t dir_rows [NUM_ROWS] = '{
    // Zero offset, ordinary rectangle and largest rectangle.
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, 16'sd0, 16'sd0}, 1'b1, '0},
    '{'{'{16'sh8000, 16'sh7fff, 15'h7fff, 15'h7fff}, 16'sd0, 16'sd0}, 1'b1, '0},
    // Full redraw with the offset exactly at the width, then at the height.
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, 16'sd100, 16'sd0}, 1'b1,
      '{16'sd10, 16'sd20, 15'd100, 15'd50}},
    '{'{'{-16'sd5, -16'sd7, 15'd40, 15'd30}, 16'sd0, -16'sd30}, 1'b1,
      '{-16'sd5, -16'sd7, 15'd40, 15'd30}},
    // Most negative offsets, which exceed every possible size.
    '{'{'{16'sh8000, 16'sh7fff, 15'h7fff, 15'h7fff}, 16'sh8000, 16'sd0}, 1'b1,
      '{16'sh8000, 16'sh7fff, 15'h7fff, 15'h7fff}},
    '{'{'{16'sh7fff, 16'sh8000, 15'd1, 15'h7fff}, 16'sd0, 16'sh8000}, 1'b1,
      '{16'sh7fff, 16'sh8000, 15'd1, 15'h7fff}},
    // Largest positive offset against the largest width.
    '{'{'{16'sd0, 16'sd0, 15'h7fff, 15'd5}, 16'sh7fff, 16'sd1}, 1'b1,
      '{16'sd0, 16'sd0, 15'h7fff, 15'd5}},
    // Full redraw of rectangles with no area reads all zero.
    '{'{'{16'sd100, 16'sd100, 15'd0, 15'd10}, 16'sd1, 16'sd0}, 1'b1, '0},
    '{'{'{-16'sd1, -16'sd1, 15'd10, 15'd0}, 16'sd0, 16'sd1}, 1'b1, '0},
    // Partial scrolls in every direction.
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, 16'sd3, 16'sd4}, 1'b0, '0},
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, -16'sd3, -16'sd4}, 1'b0, '0},
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, 16'sd7, 16'sd0}, 1'b0, '0},
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, -16'sd7, 16'sd0}, 1'b0, '0},
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, 16'sd0, 16'sd9}, 1'b0, '0},
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, 16'sd0, -16'sd9}, 1'b0, '0},
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, 16'sd5, -16'sd6}, 1'b0, '0},
    '{'{'{16'sd10, 16'sd20, 15'd100, 15'd50}, -16'sd5, 16'sd6}, 1'b0, '0},
    // Offsets one short of a full redraw.
    '{'{'{16'sd0, 16'sd0, 15'd100, 15'd50}, -16'sd99, 16'sd49}, 1'b0, '0},
    // Positions that wrap past either end of the 16 bit range.
    '{'{'{16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff}, -16'sd1, -16'sd1}, 1'b0, '0},
    '{'{'{16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff}, 16'sd32766, 16'sd32766},
      1'b0, '0},
    '{'{'{16'sh7fff, 16'sh8000, 15'h7fff, 15'h7fff}, -16'sd32766, -16'sd32766},
      1'b0, '0},
    // Smallest rectangles that still scroll partially, then the largest one.
    '{'{'{16'sh8000, 16'sd0, 15'd2, 15'd2}, 16'sd1, -16'sd1}, 1'b0, '0},
    '{'{'{16'sd5, 16'sd5, 15'd1, 15'd3}, 16'sd0, 16'sd2}, 1'b0, '0},
    '{'{'{16'sd0, 16'sd0, 15'h7fff, 15'h7fff}, 16'sd16384, -16'sd1}, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] rect_x = '0;
  logic signed [15:0] rect_y = '0;
  logic [14:0]        rect_w = '0;
  logic [14:0]        rect_h = '0;
  logic signed [15:0] shift_x = '0;
  logic signed [15:0] shift_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [14:0]        out_w;
  logic [14:0]        out_h;
  logic               last;

  scroll_rect_geometry dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rect_x    (rect_x),
    .rect_y    (rect_y),
    .rect_w    (rect_w),
    .rect_h    (rect_h),
    .shift_x   (shift_x),
    .shift_y   (shift_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_w     (out_w),
    .out_h     (out_h),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rectangles still owed by the block, oldest first.
  scroll_res_t pending_rects[$];

  int requests_sent   = 0;
  int rects_checked   = 0;
  int mismatches      = 0;
  int zero_scrolls    = 0;
  int full_redraws    = 0;
  int partial_scrolls = 0;
  int idle_cycles     = 0;
  bit long_hold_done  = 1'b0;

  // Queues one rectangle. Anything without area is sent as all zero, and
  // positions keep only their low 16 bits.
  function automatic void queue_rect(logic [1:0] k, int x, int y, int w, int h,
                                     logic lst);
    scroll_res_t res;
    res.kind = k;
    res.last = lst;
    if (w <= 0 || h <= 0) begin
      res.r = '0;
    end else begin
      res.r.x = 16'(x);
      res.r.y = 16'(y);
      res.r.w = 15'(w);
      res.r.h = 15'(h);
    end
    pending_rects.push_back(res);
  endfunction

  // Works out every rectangle that one scroll request produces. All sums are
  // done in 32 bits, so nothing wraps until queue_rect truncates.
  function automatic void predict_scroll_rects(srg_pkg::item_t req);
    int rx, ry, rw, rh, dx, dy, ax, ay;
    int vx, vy, vw, vh, bx, by, bw, bh;
    rx = int'(req.r.x);
    ry = int'(req.r.y);
    rw = int'(req.r.w);
    rh = int'(req.r.h);
    dx = int'(req.dx);
    dy = int'(req.dy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;

    if (dx == 0 && dy == 0) begin
      zero_scrolls++;
      queue_rect(srg_pkg::KIND_DIRTY0, 0, 0, 0, 0, 1'b0);
      queue_rect(srg_pkg::KIND_DIRTY1, 0, 0, 0, 0, 1'b1);
      return;
    end
    if (ax >= rw || ay >= rh) begin
      full_redraws++;
      queue_rect(srg_pkg::KIND_DIRTY0, rx, ry, rw, rh, 1'b0);
      queue_rect(srg_pkg::KIND_DIRTY1, 0, 0, 0, 0, 1'b1);
      return;
    end
    partial_scrolls++;

    // The vertical strip sits on the side the content moves away from and
    // leaves out the rows that the horizontal strip already covers.
    vx = (dx > 0) ? rx : rx + rw - ax;
    vy = (dy > 0) ? ry + ay : ry;
    vw = ax;
    vh = rh - ay;
    if (dy != 0) begin
      queue_rect(srg_pkg::KIND_DIRTY0, rx, (dy > 0) ? ry : ry + rh - ay, rw, ay, 1'b0);
      if (dx != 0) begin
        queue_rect(srg_pkg::KIND_DIRTY1, vx, vy, vw, vh, 1'b0);
      end else begin
        queue_rect(srg_pkg::KIND_DIRTY1, 0, 0, 0, 0, 1'b0);
      end
    end else begin
      queue_rect(srg_pkg::KIND_DIRTY0, vx, vy, vw, vh, 1'b0);
      queue_rect(srg_pkg::KIND_DIRTY1, 0, 0, 0, 0, 1'b0);
    end

    // The destination is the overlap with the shifted copy; the source is
    // the same area moved back by the offset.
    bx = rx + ((dx > 0) ? dx : 0);
    by = ry + ((dy > 0) ? dy : 0);
    bw = rw - ax;
    bh = rh - ay;
    queue_rect(srg_pkg::KIND_SRC, bx - dx, by - dy, bw, bh, 1'b0);
    queue_rect(srg_pkg::KIND_DST, bx, by, bw, bh, 1'b1);
  endfunction

  // Offers one request after a random gap and returns at the edge where the
  // transfer happens. Every third stretch of 40 requests has no gaps at all.
  // The expectations are queued at that edge; the first result cannot
  // appear before the next one.
  task automatic offer_scroll(input srg_pkg::item_t req, input logic lit,
                              input srg_pkg::rect_t first);
    int gap;
    gap = ((requests_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rect_x   <= req.r.x;
    rect_y   <= req.r.y;
    rect_w   <= req.r.w;
    rect_h   <= req.r.h;
    shift_x  <= req.dx;
    shift_y  <= req.dy;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (lit) begin
      pending_rects.push_back('{srg_pkg::KIND_DIRTY0, first, 1'b0});
      pending_rects.push_back('{srg_pkg::KIND_DIRTY1, srg_pkg::rect_t'('0), 1'b1});
    end else begin
      predict_scroll_rects(req);
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker. Outputs are sampled at the rising edge, before anything
  // the testbench drives at that edge takes effect.
  scroll_res_t want_rect;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rects_checked++;
      if (pending_rects.size() == 0) begin
        $error("unexpected rectangle: kind %0d x %0d y %0d w %0d h %0d last %0d",
               kind, out_x, out_y, out_w, out_h, last);
        mismatches++;
      end else begin
        want_rect = pending_rects.pop_front();
        check_field("kind", int'(want_rect.kind), int'(kind));
        check_field("out_x", int'(want_rect.r.x), int'(out_x));
        check_field("out_y", int'(want_rect.r.y), int'(out_y));
        check_field("out_w", int'(want_rect.r.w), int'(out_w));
        check_field("out_h", int'(want_rect.r.h), int'(out_h));
        check_field("last", int'(want_rect.last), int'(last));
      end
    end
  end

  // Receiver. It stalls a random number of cycles before each result, except
  // in the second of every three stretches of 50 results. Once, after 100
  // results, it holds off for a long time while the sender keeps offering, so
  // the block backs up and drops in_ready.
  initial begin : receiver
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (!long_hold_done && rects_checked >= 100) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if ((rects_checked / 50) % 3 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: a run in which neither channel moves for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d rectangles pending",
               IDLE_LIMIT, pending_rects.size());
      $display("scroll_rect_geometry_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    srg_pkg::item_t req;
    int             sel, w, h, ax, ay;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table first.
    for (int i = 0; i < NUM_ROWS; i++) begin
      offer_scroll(dir_rows[i].req, dir_rows[i].lit, dir_rows[i].first);
    end

    // Random requests. Most are partial scrolls, since only those reach the
    // strip and blit logic; the rest are zero offsets, offsets right at the
    // redraw boundary, and fully random fields that mostly redraw.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      sel = $urandom_range(0, 99);
      req.r.x = 16'($urandom);
      req.r.y = 16'($urandom);
      if (sel < 10) begin
        req.r.w = 15'($urandom);
        req.r.h = 15'($urandom);
        req.dx  = 16'($urandom);
        req.dy  = 16'($urandom);
      end else if (sel < 18) begin
        req.r.w = 15'($urandom);
        req.r.h = 15'($urandom);
        req.dx  = '0;
        req.dy  = '0;
      end else begin
        // Sizes are mostly small with an occasional large one.
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 64);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 64);
        if (sel < 26) begin
          // One of the offsets lands exactly on the size.
          ax = $urandom_range(0, 1) ? w : $urandom_range(0, w - 1);
          ay = (ax == w) ? $urandom_range(0, h - 1) : h;
        end else begin
          ax = $urandom_range(0, w - 1);
          ay = $urandom_range(0, h - 1);
        end
        req.r.w = 15'(w);
        req.r.h = 15'(h);
        req.dx  = 16'($urandom_range(0, 1) ? -ax : ax);
        req.dy  = 16'($urandom_range(0, 1) ? -ay : ay);
      end
      offer_scroll(req, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then give any stray result time to show up.
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d scroll requests (%0d from the directed table), %0d rectangles checked",
             requests_sent, NUM_ROWS, rects_checked);
    $display("predicted: %0d zero offsets, %0d full redraws, %0d partial scrolls",
             zero_scrolls, full_redraws, partial_scrolls);
    if (mismatches == 0) begin
      $display("scroll_rect_geometry_test: PASS");
    end else begin
      $display("scroll_rect_geometry_test: FAIL");
    end
    $finish;
  end

endmodule
